// File: sv/circular_deque_defines.svh
// assertion macros used by the circular deque controller
// no dependencies; expects clk and rst_n in the including scope
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// same-cycle implication, off while reset is held
`define CDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cdq_pkg.sv
// shared constants, codes, beat types and pointer helpers of the circular deque
// no dependencies
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_e;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } emit_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

endpackage

// File: sv/circular_deque.sv
// circular deque top level: controller, ring store and output register
// depends on cdq_pkg, cdq_ram and cdq_ctrl
//
//   channel   ports                        beat
//   input     in_valid / in_stall          in_beat  (op, value)
//   result    out_valid / out_stall        out_beat (status, data, last, occupancy)
//
// push, pop and refused operations pass through accept, then the emit state; a pop reads the
// single ram read port, which returns its registered data during the emit state.
// a dump of n elements emits n result beats, one ram read per element.
// each result beat passes through the output register before it shows on out_valid.
// reset clears state, head, tail, count and beats left; the ring store is not cleared.
// out_stall holds the output register and the controller waits in its emit state.
module circular_deque (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cdq_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output cdq_pkg::out_beat_t out_beat
);

  cdq_pkg::emit_t            emit;
  cdq_pkg::ram_req_t         ram_req;
  logic [cdq_pkg::DATA_W-1:0] ram_rdata;
  logic                      out_free;
  logic                      out_valid_r;
  cdq_pkg::out_beat_t        out_beat_r;

  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .emit       (emit),
    .emit_ready (out_free),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  cdq_ram #(
    .DATA_W (cdq_pkg::DATA_W),
    .DEPTH  (cdq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output register takes a beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.valid) begin
      out_beat_r <= emit.beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// File: sv/cdq_ram.sv
// ring store: one write port, one read port, registered read data
// no dependencies
module cdq_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/cdq_ctrl.sv
// deque controller: head/tail/count, ram accesses, result sequencing
// depends on cdq_pkg and circular_deque_defines.svh
`include "circular_deque_defines.svh"

module cdq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cdq_pkg::in_beat_t   in_beat,
  output cdq_pkg::emit_t      emit,
  input  logic                emit_ready,
  output cdq_pkg::ram_req_t   ram_req,
  input  logic [cdq_pkg::DATA_W-1:0] ram_rdata
);

  cdq_pkg::state_e                 state_r, state_nxt;
  logic [cdq_pkg::IDX_W-1:0]       head_r, head_nxt;
  logic [cdq_pkg::IDX_W-1:0]       tail_r, tail_nxt;
  logic [cdq_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [cdq_pkg::CNT_W-1:0]       left_r, left_nxt;
  logic [cdq_pkg::IDX_W-1:0]       dump_idx_r, dump_idx_nxt;
  cdq_pkg::stat_e                  stat_r, stat_nxt;
  logic                            use_rd_r, use_rd_nxt;

  logic accept;
  logic full;
  logic empty;
  logic known_op;
  logic is_push;
  logic last_beat;

  assign accept    = in_valid && !in_stall;
  assign full      = (cnt_r == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
  assign empty     = (cnt_r == '0);
  assign last_beat = (left_r == cdq_pkg::CNT_W'(1));
  assign is_push   = (in_beat.op == cdq_pkg::OP_PUSH_FRONT) ||
                     (in_beat.op == cdq_pkg::OP_PUSH_REAR);
  assign known_op  = is_push ||
                     (in_beat.op == cdq_pkg::OP_POP_FRONT) ||
                     (in_beat.op == cdq_pkg::OP_POP_REAR) ||
                     (in_beat.op == cdq_pkg::OP_DUMP);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdq_pkg::S_IDLE: begin
        if (accept && known_op) begin
          state_nxt = cdq_pkg::S_EMIT;
        end
      end
      cdq_pkg::S_EMIT: begin
        if (emit_ready && last_beat) begin
          state_nxt = cdq_pkg::S_IDLE;
        end
      end
      default: state_nxt = cdq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall            = 1'b1;
    emit.valid          = 1'b0;
    emit.beat.status    = stat_r;
    emit.beat.data      = use_rd_r ? signed'(ram_rdata) : '0;
    emit.beat.last      = last_beat;
    emit.beat.occupancy = cdq_pkg::OCC_W'(cnt_r);
    case (state_r)
      cdq_pkg::S_IDLE: in_stall   = 1'b0;
      cdq_pkg::S_EMIT: emit.valid = 1'b1;
      default:         in_stall   = 1'b1;
    endcase
  end

  // pointer update and ram access; one access per cycle, so no overlap on an entry
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    left_nxt     = left_r;
    dump_idx_nxt = dump_idx_r;
    stat_nxt     = stat_r;
    use_rd_nxt   = use_rd_r;
    ram_req      = '0;
    ram_req.wdata = in_beat.value;

    if (accept) begin
      stat_nxt   = cdq_pkg::ST_DONE;
      use_rd_nxt = 1'b0;
      left_nxt   = cdq_pkg::CNT_W'(1);
      case (in_beat.op)
        cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
          if (full) begin
            stat_nxt = cdq_pkg::ST_FULL;
          end else begin
            ram_req.we = 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
            if (empty) begin
              head_nxt      = '0;
              tail_nxt      = '0;
              ram_req.waddr = '0;
            end else if (in_beat.op == cdq_pkg::OP_PUSH_FRONT) begin
              head_nxt      = cdq_pkg::wrap_dec(head_r);
              ram_req.waddr = cdq_pkg::wrap_dec(head_r);
            end else begin
              tail_nxt      = cdq_pkg::wrap_inc(tail_r);
              ram_req.waddr = cdq_pkg::wrap_inc(tail_r);
            end
          end
        end
        cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
          if (empty) begin
            stat_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = (in_beat.op == cdq_pkg::OP_POP_FRONT) ? head_r : tail_r;
            use_rd_nxt    = 1'b1;
            cnt_nxt       = cnt_r - 1'b1;
            if (cnt_r == cdq_pkg::CNT_W'(1)) begin
              head_nxt = '0;
              tail_nxt = '0;
            end else if (in_beat.op == cdq_pkg::OP_POP_FRONT) begin
              head_nxt = cdq_pkg::wrap_inc(head_r);
            end else begin
              tail_nxt = cdq_pkg::wrap_dec(tail_r);
            end
          end
        end
        cdq_pkg::OP_DUMP: begin
          if (empty) begin
            stat_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = head_r;
            use_rd_nxt    = 1'b1;
            left_nxt      = cnt_r;
            dump_idx_nxt  = cdq_pkg::wrap_inc(head_r);
          end
        end
        default: begin
          stat_nxt = stat_r;
        end
      endcase
    end else if (state_r == cdq_pkg::S_EMIT && emit_ready && !last_beat) begin
      // dump: fetch the next element while the current one leaves
      ram_req.re    = 1'b1;
      ram_req.raddr = dump_idx_r;
      dump_idx_nxt  = cdq_pkg::wrap_inc(dump_idx_r);
      left_nxt      = left_r - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    dump_idx_r <= dump_idx_nxt;
    stat_r     <= stat_nxt;
    use_rd_r   <= use_rd_nxt;
  end

  `CDQ_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH), "count above depth")
  `CDQ_ASSERT_NOW(a_empty_ptrs, empty, head_r == '0 && tail_r == '0, "empty deque with moved pointers")
  `CDQ_ASSERT_NOW(a_emit_no_write, state_r == cdq_pkg::S_EMIT, !ram_req.we, "ram write while emitting")
  `CDQ_ASSERT_NOW(a_emit_left, state_r == cdq_pkg::S_EMIT, left_r != '0, "emitting with no beats left")
  `CDQ_ASSERT_NEXT(a_push_count, accept && is_push && !full, cnt_r == $past(cnt_r) + cdq_pkg::CNT_W'(1), "push did not grow count")

endmodule

// File: test/tb_circular_deque.sv
// self-checking testbench for the circular deque: a directed table, then random beats
// depends on cdq_pkg and circular_deque; results are checked against an in-bench deque
module tb_circular_deque;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 190;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 24;
  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_AT      = 60;
  localparam int PAUSE_AT     = 150;
  localparam int PLAN_ROWS    = 16;

  // op codes the block ignores
  localparam logic [cdq_pkg::OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [cdq_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [cdq_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam logic signed [cdq_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [cdq_pkg::DATA_W-1:0] VAL_MIN = 32'sh80000000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  cdq_pkg::in_beat_t  in_beat   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  cdq_pkg::out_beat_t out_beat;

  // expected result beats, oldest first
  cdq_pkg::out_beat_t pending_results [$];
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;
  int        burst_left     = 0;
  bit        hold_request   = 1'b0;

  // shadow copy of the deque
  logic signed [cdq_pkg::DATA_W-1:0] shadow_ring [cdq_pkg::DEPTH];
  int unsigned              shadow_head  = 0;
  int unsigned              shadow_tail  = 0;
  int unsigned              shadow_count = 0;

  // one row of directed stimulus; expected beat given only where obvious
  typedef struct {
    logic [cdq_pkg::OP_W-1:0]          op;
    logic signed [cdq_pkg::DATA_W-1:0] value;
    bit                                random_value;
    int                                repeats;
    bit                                typed;
    cdq_pkg::stat_e                    exp_status;
    logic signed [cdq_pkg::DATA_W-1:0] exp_data;
    logic [cdq_pkg::OCC_W-1:0]         exp_occupancy;
  } plan_row_t;

  plan_row_t plan [PLAN_ROWS] = '{
    '{cdq_pkg::OP_POP_FRONT,  32'sd0,  1'b0, 1,  1'b1, cdq_pkg::ST_EMPTY, 32'sd0,  5'd0},
    '{cdq_pkg::OP_POP_REAR,   32'sd0,  1'b0, 1,  1'b1, cdq_pkg::ST_EMPTY, 32'sd0,  5'd0},
    '{cdq_pkg::OP_DUMP,       32'sd0,  1'b0, 1,  1'b1, cdq_pkg::ST_EMPTY, 32'sd0,  5'd0},
    '{OP_RSVD_5,              32'sd0,  1'b1, 1,  1'b0, cdq_pkg::ST_DONE,  32'sd0,  5'd0},
    '{cdq_pkg::OP_PUSH_FRONT, VAL_MAX, 1'b0, 1,  1'b1, cdq_pkg::ST_DONE,  32'sd0,  5'd1},
    // single element popped: deque goes empty again
    '{cdq_pkg::OP_POP_REAR,   32'sd0,  1'b0, 1,  1'b1, cdq_pkg::ST_DONE,  VAL_MAX, 5'd0},
    '{cdq_pkg::OP_PUSH_REAR,  VAL_MIN, 1'b0, 1,  1'b1, cdq_pkg::ST_DONE,  32'sd0,  5'd1},
    '{cdq_pkg::OP_PUSH_FRONT, VAL_MAX, 1'b0, 1,  1'b1, cdq_pkg::ST_DONE,  32'sd0,  5'd2},
    '{cdq_pkg::OP_PUSH_REAR,  32'sd0,  1'b1, 14, 1'b0, cdq_pkg::ST_DONE,  32'sd0,  5'd0},
    // full: both pushes refused
    '{cdq_pkg::OP_PUSH_FRONT, VAL_MIN, 1'b0, 1,  1'b1, cdq_pkg::ST_FULL,  32'sd0,  5'd16},
    '{cdq_pkg::OP_PUSH_REAR,  VAL_MAX, 1'b0, 1,  1'b1, cdq_pkg::ST_FULL,  32'sd0,  5'd16},
    '{cdq_pkg::OP_DUMP,       32'sd0,  1'b0, 1,  1'b0, cdq_pkg::ST_DONE,  32'sd0,  5'd0},
    '{cdq_pkg::OP_POP_FRONT,  32'sd0,  1'b0, 1,  1'b0, cdq_pkg::ST_DONE,  32'sd0,  5'd0},
    '{cdq_pkg::OP_POP_REAR,   32'sd0,  1'b0, 1,  1'b0, cdq_pkg::ST_DONE,  32'sd0,  5'd0},
    '{OP_RSVD_6,              32'sd0,  1'b1, 1,  1'b0, cdq_pkg::ST_DONE,  32'sd0,  5'd0},
    '{OP_RSVD_7,              32'sd0,  1'b1, 1,  1'b0, cdq_pkg::ST_DONE,  32'sd0,  5'd0}
  };

  circular_deque u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  // clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic cdq_pkg::out_beat_t make_result(cdq_pkg::stat_e st,
                                                     logic signed [cdq_pkg::DATA_W-1:0] d,
                                                     logic lst);
    cdq_pkg::out_beat_t r;
    r.status    = st;
    r.data      = d;
    r.last      = lst;
    r.occupancy = cdq_pkg::OCC_W'(shadow_count);
    return r;
  endfunction

  // apply one op to the shadow deque and queue the beats it should produce
  task automatic apply_deque_op(input cdq_pkg::in_beat_t b);
    int unsigned                       slot;
    logic signed [cdq_pkg::DATA_W-1:0] word;
    case (b.op)
      cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
        if (shadow_count == cdq_pkg::DEPTH) begin
          pending_results.push_back(make_result(cdq_pkg::ST_FULL, '0, 1'b1));
        end else begin
          if (shadow_count == 0) begin
            shadow_head = 0;
            shadow_tail = 0;
          end else if (b.op == cdq_pkg::OP_PUSH_FRONT) begin
            shadow_head = (shadow_head + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
          end else begin
            shadow_tail = (shadow_tail + 1) % cdq_pkg::DEPTH;
          end
          slot = (b.op == cdq_pkg::OP_PUSH_FRONT) ? shadow_head : shadow_tail;
          shadow_ring[slot] = b.value;
          shadow_count++;
          pending_results.push_back(make_result(cdq_pkg::ST_DONE, '0, 1'b1));
        end
      end
      cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
        if (shadow_count == 0) begin
          pending_results.push_back(make_result(cdq_pkg::ST_EMPTY, '0, 1'b1));
        end else begin
          word = (b.op == cdq_pkg::OP_POP_FRONT) ? shadow_ring[shadow_head]
                                                 : shadow_ring[shadow_tail];
          shadow_count--;
          if (shadow_count == 0) begin
            shadow_head = 0;
            shadow_tail = 0;
          end else if (b.op == cdq_pkg::OP_POP_FRONT) begin
            shadow_head = (shadow_head + 1) % cdq_pkg::DEPTH;
          end else begin
            shadow_tail = (shadow_tail + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
          end
          pending_results.push_back(make_result(cdq_pkg::ST_DONE, word, 1'b1));
        end
      end
      cdq_pkg::OP_DUMP: begin
        if (shadow_count == 0) begin
          pending_results.push_back(make_result(cdq_pkg::ST_EMPTY, '0, 1'b1));
        end else begin
          slot = shadow_head;
          for (int n = 0; n < shadow_count; n++) begin
            pending_results.push_back(make_result(cdq_pkg::ST_DONE, shadow_ring[slot],
                                                  n + 1 == shadow_count));
            slot = (slot + 1) % cdq_pkg::DEPTH;
          end
        end
      end
      default: begin
        // reserved op: no beat, no change
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // sender gap: mostly none, some short, a few long, with gap-free bursts
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 5) begin
      burst_left = 30;
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // offer one beat; on acceptance update the shadow deque, optionally
  // replacing its single predicted beat with a hand-written one
  task automatic offer_beat(input cdq_pkg::in_beat_t b, input int gap, input bit use_typed,
                            input cdq_pkg::out_beat_t typed_res);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_deque_op(b);
    if (use_typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(typed_res);
    end
    @(negedge clk);
  endtask

  function automatic logic signed [cdq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // receiver stall pattern, with one long hold on request
  initial begin : receiver
    int  r;
    int  stall_len;
    bit  stall_level;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_level  = 1'b1;
        stall_len    = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          stall_level = 1'b0;
          stall_len   = 40;
        end else if (r < 60) begin
          stall_level = 1'b0;
          stall_len   = $urandom_range(1, 4);
        end else if (r < 92) begin
          stall_level = 1'b1;
          stall_len   = $urandom_range(1, 3);
        end else begin
          stall_level = 1'b1;
          stall_len   = $urandom_range(8, 20);
        end
      end
      out_stall <= stall_level;
      repeat (stall_len) @(negedge clk);
    end
  end

  // compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    cdq_pkg::out_beat_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_beat.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_beat.status, want.status));
        if (out_beat.data !== want.data)
          report_mismatch($sformatf("data got %0d want %0d", out_beat.data, want.data));
        if (out_beat.last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_beat.last, want.last));
        if (out_beat.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy got %0d want %0d",
                                    out_beat.occupancy, want.occupancy));
      end
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus: directed table, then random traffic
  initial begin : stimulus
    cdq_pkg::in_beat_t  beat;
    cdq_pkg::out_beat_t typed_res;
    int                 counted;
    int                 r;
    bit                 filling;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < PLAN_ROWS; i++) begin
      for (int k = 0; k < plan[i].repeats; k++) begin
        beat.op             = plan[i].op;
        beat.value          = plan[i].random_value ? $urandom : plan[i].value;
        typed_res.status    = plan[i].exp_status;
        typed_res.data      = plan[i].exp_data;
        typed_res.last      = 1'b1;
        typed_res.occupancy = plan[i].exp_occupancy;
        offer_beat(beat, pick_gap(), plan[i].typed, typed_res);
      end
    end

    // random traffic, alternating push-heavy and pop-heavy stretches
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      filling = ((counted / 40) % 2) == 0;
      r = $urandom_range(0, 99);
      beat.value = pick_value();
      if (r < 4) begin
        case ($urandom_range(0, 2))
          0: beat.op = OP_RSVD_5;
          1: beat.op = OP_RSVD_6;
          default: beat.op = OP_RSVD_7;
        endcase
      end else if (r < 12) begin
        beat.op = cdq_pkg::OP_DUMP;
      end else if (r < (filling ? 72 : 37)) begin
        beat.op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR;
      end else begin
        beat.op = $urandom_range(0, 1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR;
      end
      offer_beat(beat, pick_gap(), 1'b0, '0);
      if (r >= 4) begin
        counted++;
        // long receiver hold while beats keep coming
        if (counted == HOLD_AT) hold_request = 1'b1;
        // sender waits for every outstanding result
        if (counted == PAUSE_AT) begin
          in_valid <= 1'b0;
          do @(negedge clk); while (pending_results.size() != 0);
        end
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/circular_deque.sv
test/tb_circular_deque.sv
